// ----- rtl/core/bba_pkg.sv -----
// Buddy allocator package: command, status and register-index codes.
// No dependencies; used by the allocator top level, the checker and the testbench.
package bba_pkg;

  localparam int STATUS_W = 3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic CFG_POOL_ORDER = 1'b0;
  localparam logic CFG_BASE_ADDR  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ALLOCATED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FREED        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_MEMORY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd4;

endpackage

// ----- rtl/core/bba_ram.sv -----
// Simple dual-port RAM: one write port, one read port with registered data.
// Standalone; used by the allocator top level for per-block tables.
module bba_ram #(
  parameter int W      = 8,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [W-1:0]      wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [W-1:0]      rdata
);

  logic [W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/buddy_block_allocator_top.sv -----
// Binary buddy allocator: one sequencer walking orders over block tables in RAM.
// Depends on bba_pkg and bba_ram.
//
// One command at a time. An allocate tries orders upward for the size, probes
// the free lists from there, reads and unlinks the block it finds, splits it
// down an order per split, pushing the upper half, and finishes; a free checks
// the address and the block's metadata, checks and merges buddies and pushes
// the result. After reset and after any pool_order write the block clears its
// order/free table, one entry per cycle, with in_ready low. A finished result
// waits in the output register while the next command is taken.
module buddy_block_allocator_top #(
  parameter int MIN_BLOCK_BYTES = 64,
  parameter int MAX_ORDER       = 10,
  parameter int HEADER_BYTES    = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [31:0] request_bytes,
  input  logic [47:0] free_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] block_address,
  output logic [bba_pkg::STATUS_W-1:0] status,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int IW    = MAX_ORDER;
  localparam int LW    = MAX_ORDER + 1;
  localparam int OW    = $clog2(MAX_ORDER + 1);
  localparam int JW    = OW + 1;
  localparam int SHIFT = $clog2(MIN_BLOCK_BYTES);
  localparam int PO_RESET = (10 > MAX_ORDER) ? MAX_ORDER : 10;
  localparam logic [LW-1:0] NIL = {1'b1, {IW{1'b0}}};

  typedef enum logic [4:0] {
    S_CLEAR, S_INIT, S_IDLE,
    S_A_NEED, S_A_SRCH, S_A_RD, S_A_UNL, S_A_SPL, S_A_FIN,
    S_F_SUB1, S_F_SUB2, S_F_CHK, S_F_RD, S_F_META, S_F_LOOP, S_F_BRD, S_F_BUD,
    S_PUSH1, S_PUSH2, S_DONE
  } state_t;

  state_t        state;
  logic [OW-1:0] pool_order;
  logic [47:0]   base_address;
  logic [IW-1:0] clr_cnt;
  logic          cmd_q;
  logic [33:0]   total;
  logic [47:0]   addr_w;
  logic [JW-1:0] need;
  logic [JW-1:0] j;
  logic [JW-1:0] ord;
  logic [IW-1:0] idx;
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] push_x;
  logic [OW-1:0] push_o;
  logic [LW-1:0] push_first;
  logic [47:0]   res_addr;
  logic [bba_pkg::STATUS_W-1:0] res_status;
  logic [LW-1:0] head [MAX_ORDER+1];

  // table ports
  logic          meta_we, nx_we, pv_we, hd_we;
  logic [IW-1:0] meta_wa, nx_wa, pv_wa;
  logic [OW:0]   meta_wd, meta_rd;
  logic [LW-1:0] nx_wd, pv_wd, nx_rd, pv_rd, hd_wd, hd;
  logic [OW-1:0] hd_wa, hsel;

  logic [OW-1:0] rd_ord, rd_ord_cl;
  logic          rd_free;
  logic          merge_ok;
  logic [JW-1:0] jm;
  logic [IW:0]   omask;
  logic [48:0]   diff;
  logic [JW-1:0] po_x;

  bba_ram #(.W(OW + 1), .ADDR_W(IW)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_wa), .wdata(meta_wd),
    .raddr(rd_idx), .rdata(meta_rd)
  );
  bba_ram #(.W(LW), .ADDR_W(IW)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
    .raddr(rd_idx), .rdata(nx_rd)
  );
  bba_ram #(.W(LW), .ADDR_W(IW)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
    .raddr(rd_idx), .rdata(pv_rd)
  );

  assign rd_free   = meta_rd[OW];
  assign rd_ord    = meta_rd[OW-1:0];
  assign rd_ord_cl = (rd_ord > MAX_ORDER) ? OW'(MAX_ORDER) : rd_ord;
  assign po_x      = {1'b0, pool_order};
  assign merge_ok  = rd_free && ({1'b0, rd_ord} == ord);
  assign jm        = j - 1'b1;
  assign omask     = ((IW + 1)'(1) << rd_ord) - 1'b1;
  assign hsel      = (state == S_PUSH1) ? push_o : j[OW-1:0];
  assign hd        = head[hsel];
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    diff = '0;
    case (state)
      S_F_SUB1: diff = {1'b0, addr_w} - 49'(HEADER_BYTES);
      S_F_SUB2: diff = {1'b0, addr_w} - {1'b0, base_address};
      default:  diff = '0;
    endcase
  end

  // table writes
  always_comb begin
    meta_we = 1'b0; meta_wa = rd_idx; meta_wd = '0;
    nx_we   = 1'b0; nx_wa   = rd_idx; nx_wd   = NIL;
    pv_we   = 1'b0; pv_wa   = rd_idx; pv_wd   = NIL;
    hd_we   = 1'b0; hd_wa   = hsel;   hd_wd   = NIL;
    unique case (state)
      S_CLEAR: begin
        meta_we = 1'b1;
        meta_wa = clr_cnt;
      end
      S_INIT: begin
        meta_we = 1'b1; meta_wa = '0; meta_wd = {1'b1, pool_order};
        nx_we   = 1'b1; nx_wa   = '0;
        pv_we   = 1'b1; pv_wa   = '0;
        hd_we   = 1'b1; hd_wa   = pool_order; hd_wd = '0;
      end
      S_A_UNL, S_F_BUD: begin
        // unlink the node at rd_idx
        if (state == S_A_UNL || merge_ok) begin
          if (pv_rd == NIL) begin
            hd_we = 1'b1;
            hd_wa = rd_ord_cl;
            hd_wd = nx_rd;
          end else begin
            nx_we = 1'b1;
            nx_wa = pv_rd[IW-1:0];
            nx_wd = nx_rd;
          end
          pv_we   = (nx_rd != NIL);
          pv_wa   = nx_rd[IW-1:0];
          pv_wd   = pv_rd;
          meta_we = 1'b1;
          meta_wa = rd_idx;
          meta_wd = {1'b0, rd_ord};
        end
      end
      S_A_FIN: begin
        meta_we = 1'b1; meta_wa = idx; meta_wd = {1'b0, need[OW-1:0]};
      end
      S_PUSH1: begin
        nx_we   = 1'b1; nx_wa   = push_x; nx_wd = hd;
        pv_we   = 1'b1; pv_wa   = push_x;
        meta_we = 1'b1; meta_wa = push_x; meta_wd = {1'b1, push_o};
        hd_we   = 1'b1; hd_wa   = push_o; hd_wd = {1'b0, push_x};
      end
      S_PUSH2: begin
        pv_we = (push_first != NIL);
        pv_wa = push_first[IW-1:0];
        pv_wd = {1'b0, push_x};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      pool_order   <= OW'(PO_RESET);
      base_address <= '0;
      clr_cnt      <= '0;
      out_valid    <= 1'b0;
      for (int k = 0; k <= MAX_ORDER; k++) head[k] <= NIL;
    end else if (cfg_write && cfg_index == bba_pkg::CFG_POOL_ORDER) begin
      // a pool_order write rebuilds the pool
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      pool_order <= (cfg_data[3:0] > MAX_ORDER) ? OW'(MAX_ORDER) : OW'(cfg_data[3:0]);
      clr_cnt    <= '0;
      state      <= S_CLEAR;
      for (int k = 0; k <= MAX_ORDER; k++) head[k] <= NIL;
    end else begin
      if (hd_we) begin
        head[hd_wa] <= hd_wd;
      end
      if (cfg_write) begin
        base_address <= cfg_data;
      end
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= S_INIT;
          end
        end
        S_INIT: state <= S_IDLE;
        S_IDLE: begin
          if (in_valid) begin
            cmd_q    <= cmd;
            total    <= {2'b00, request_bytes} + 34'(HEADER_BYTES);
            addr_w   <= free_address;
            need     <= '0;
            res_addr <= '0;
            state    <= (cmd == bba_pkg::CMD_ALLOC) ? S_A_NEED : S_F_SUB1;
          end
        end
        S_A_NEED: begin
          if (need > po_x) begin
            res_status <= bba_pkg::ST_NO_MEMORY;
            state      <= S_DONE;
          end else if ((34'(MIN_BLOCK_BYTES) << need) >= total) begin
            j     <= need;
            state <= S_A_SRCH;
          end else begin
            need <= need + 1'b1;
          end
        end
        S_A_SRCH: begin
          if (j > po_x) begin
            res_status <= bba_pkg::ST_NO_MEMORY;
            state      <= S_DONE;
          end else if (hd != NIL) begin
            idx    <= hd[IW-1:0];
            rd_idx <= hd[IW-1:0];
            state  <= S_A_RD;
          end else begin
            j <= j + 1'b1;
          end
        end
        S_A_RD:  state <= S_A_UNL;
        S_A_UNL: state <= S_A_SPL;
        S_A_SPL: begin
          if (j > need) begin
            j      <= jm;
            push_x <= idx + (IW'(1) << jm);
            push_o <= jm[OW-1:0];
            state  <= S_PUSH1;
          end else begin
            state <= S_A_FIN;
          end
        end
        S_A_FIN: begin
          res_addr   <= base_address + (48'(idx) << SHIFT) + 48'(HEADER_BYTES);
          res_status <= bba_pkg::ST_ALLOCATED;
          state      <= S_DONE;
        end
        S_F_SUB1: begin
          if (diff[48]) begin
            res_status <= bba_pkg::ST_OUT_OF_RANGE;
            state      <= S_DONE;
          end else begin
            addr_w <= diff[47:0];
            state  <= S_F_SUB2;
          end
        end
        S_F_SUB2: begin
          if (diff[48]) begin
            res_status <= bba_pkg::ST_OUT_OF_RANGE;
            state      <= S_DONE;
          end else begin
            addr_w <= diff[47:0];
            state  <= S_F_CHK;
          end
        end
        S_F_CHK: begin
          if ((addr_w >> (SHIFT + int'(pool_order))) != '0 ||
              addr_w[SHIFT-1:0] != '0) begin
            res_status <= bba_pkg::ST_OUT_OF_RANGE;
            state      <= S_DONE;
          end else begin
            idx    <= addr_w[SHIFT +: IW];
            rd_idx <= addr_w[SHIFT +: IW];
            state  <= S_F_RD;
          end
        end
        S_F_RD: state <= S_F_META;
        S_F_META: begin
          if (rd_ord > pool_order || (idx & omask[IW-1:0]) != '0) begin
            res_status <= bba_pkg::ST_OUT_OF_RANGE;
            state      <= S_DONE;
          end else if (rd_free) begin
            res_status <= bba_pkg::ST_ALREADY_FREE;
            state      <= S_DONE;
          end else begin
            ord   <= {1'b0, rd_ord};
            state <= S_F_LOOP;
          end
        end
        S_F_LOOP: begin
          if (ord < po_x) begin
            rd_idx <= idx ^ (IW'(1) << ord);
            state  <= S_F_BRD;
          end else begin
            push_x <= idx;
            push_o <= ord[OW-1:0];
            state  <= S_PUSH1;
          end
        end
        S_F_BRD: state <= S_F_BUD;
        S_F_BUD: begin
          if (merge_ok) begin
            if (rd_idx < idx) begin
              idx <= rd_idx;
            end
            ord   <= ord + 1'b1;
            state <= S_F_LOOP;
          end else begin
            push_x <= idx;
            push_o <= ord[OW-1:0];
            state  <= S_PUSH1;
          end
        end
        S_PUSH1: begin
          push_first <= hd;
          state      <= S_PUSH2;
        end
        S_PUSH2: begin
          if (cmd_q == bba_pkg::CMD_ALLOC) begin
            state <= S_A_SPL;
          end else begin
            res_status <= bba_pkg::ST_FREED;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            block_address <= res_addr;
            status        <= res_status;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_cfg_rebuild: assert property (@(posedge clk) disable iff (rst)
    cfg_write && cfg_index == bba_pkg::CFG_POOL_ORDER |=> !in_ready)
    else $error("pool rebuild did not block commands");

  a_addr_only_alloc: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != bba_pkg::ST_ALLOCATED |-> block_address == '0)
    else $error("nonzero address on a non-allocate result");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= bba_pkg::ST_ALREADY_FREE)
    else $error("status code out of range");
`endif

endmodule

// ----- tb/bba_checker.sv -----
// Buddy allocator checker: watches the command, result and register ports,
// predicts each result from its own copy of the free lists and compares it.
// Depends on bba_pkg.
`timescale 1ns / 100ps

module bba_checker #(
  parameter int MIN_BLOCK_BYTES = 64,
  parameter int MAX_ORDER       = 10,
  parameter int HEADER_BYTES    = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        cmd,
  input  logic [31:0] request_bytes,
  input  logic [47:0] free_address,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [47:0] block_address,
  input  logic [bba_pkg::STATUS_W-1:0] status,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data,
  output int          fail_count,
  output int          outstanding
);

  localparam int unsigned SLOTS = 1 << MAX_ORDER;
  localparam int unsigned NIL   = SLOTS;

  typedef struct packed {
    logic [47:0]                  addr;
    logic [bba_pkg::STATUS_W-1:0] st;
  } grant_t;

  grant_t      grants_due[$];
  logic        free_mark [SLOTS];
  logic [3:0]  blk_order [SLOTS];
  int unsigned nxt [SLOTS];
  int unsigned prv [SLOTS];
  int unsigned list_top [MAX_ORDER+1];
  int unsigned pool_order;
  logic [47:0] pool_base;

  assign outstanding = grants_due.size();

  function automatic void push_free(int unsigned idx, int unsigned ord);
    int unsigned first;
    first = list_top[ord];
    idx = idx & (SLOTS - 1);
    nxt[idx] = first;
    prv[idx] = NIL;
    if (first != NIL) prv[first & (SLOTS - 1)] = idx;
    list_top[ord] = idx;
    free_mark[idx] = 1'b1;
    blk_order[idx] = ord[3:0];
  endfunction

  function automatic void unlink_free(int unsigned idx);
    int unsigned n, p, ord;
    idx = idx & (SLOTS - 1);
    n = nxt[idx];
    p = prv[idx];
    ord = blk_order[idx];
    if (ord > MAX_ORDER) ord = MAX_ORDER;
    if (p == NIL) list_top[ord] = n;
    else nxt[p & (SLOTS - 1)] = n;
    if (n != NIL) prv[n & (SLOTS - 1)] = p;
    free_mark[idx] = 1'b0;
  endfunction

  function automatic void clear_pool();
    for (int i = 0; i < SLOTS; i++) begin
      free_mark[i] = 1'b0;
      blk_order[i] = '0;
      nxt[i] = NIL;
      prv[i] = NIL;
    end
    for (int i = 0; i <= MAX_ORDER; i++) list_top[i] = NIL;
    push_free(0, pool_order);
  endfunction

  function automatic grant_t allocate(logic [31:0] req);
    grant_t      g;
    logic [63:0] total;
    int unsigned need, j, idx;
    g.addr = '0;
    g.st = bba_pkg::ST_NO_MEMORY;
    total = 64'(req) + 64'(HEADER_BYTES);
    need = 0;
    while (need <= pool_order && (64'(MIN_BLOCK_BYTES) << need) < total) need++;
    if (need > pool_order) return g;
    for (j = need; j <= pool_order; j++)
      if (list_top[j] != NIL) break;
    if (j > pool_order) return g;
    idx = list_top[j] & (SLOTS - 1);
    unlink_free(idx);
    while (j > need) begin
      j--;
      push_free(idx + (1 << j), j);
    end
    free_mark[idx] = 1'b0;
    blk_order[idx] = need[3:0];
    g.addr = pool_base + 48'(idx * MIN_BLOCK_BYTES) + 48'(HEADER_BYTES);
    g.st = bba_pkg::ST_ALLOCATED;
    return g;
  endfunction

  function automatic grant_t release_block(logic [47:0] fa);
    grant_t      g;
    logic [47:0] hdr, off;
    logic [63:0] pool_bytes;
    int unsigned idx, ord, buddy;
    g.addr = '0;
    g.st = bba_pkg::ST_OUT_OF_RANGE;
    if (fa < 48'(HEADER_BYTES)) return g;
    hdr = fa - 48'(HEADER_BYTES);
    if (hdr < pool_base) return g;
    off = hdr - pool_base;
    pool_bytes = 64'(MIN_BLOCK_BYTES) << pool_order;
    if (64'(off) >= pool_bytes || (off % MIN_BLOCK_BYTES) != 0) return g;
    idx = int'(off / MIN_BLOCK_BYTES) & (SLOTS - 1);
    ord = blk_order[idx];
    if (ord > pool_order || (idx & ((1 << ord) - 1)) != 0) return g;
    if (free_mark[idx]) begin
      g.st = bba_pkg::ST_ALREADY_FREE;
      return g;
    end
    while (ord < pool_order) begin
      buddy = (idx ^ (1 << ord)) & (SLOTS - 1);
      if (!free_mark[buddy] || blk_order[buddy] != ord) break;
      unlink_free(buddy);
      if (buddy < idx) idx = buddy;
      ord++;
    end
    push_free(idx, ord);
    g.st = bba_pkg::ST_FREED;
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t g;
    if (rst) begin
      pool_order = MAX_ORDER < 10 ? MAX_ORDER : 10;
      pool_base = '0;
      clear_pool();
      grants_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == bba_pkg::CFG_POOL_ORDER) begin
          pool_order = (cfg_data[3:0] > MAX_ORDER) ? MAX_ORDER : cfg_data[3:0];
          clear_pool();
        end else begin
          pool_base = cfg_data;
        end
      end
      if (in_valid && in_ready) begin
        if (cmd == bba_pkg::CMD_ALLOC) g = allocate(request_bytes);
        else g = release_block(free_address);
        grants_due.push_back(g);
      end
      if (out_valid && out_ready) begin
        if (grants_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result beat: addr %h status %0d", block_address, status);
        end else begin
          g = grants_due.pop_front();
          if (g.addr !== block_address || g.st !== status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected addr %h status %0d, got addr %h status %0d",
                       g.addr, g.st, block_address, status);
          end
        end
      end
    end
  end

endmodule

// ----- tb/tb.sv -----
// Top of the buddy allocator testbench: clock, reset, command and register stimulus,
// result backpressure and verdict. Depends on bba_pkg, allocator top and bba_checker.
`timescale 1ns / 100ps

module tb;

  localparam int LIMIT = 2000000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        cmd;
  logic [31:0] request_bytes;
  logic [47:0] free_address;
  logic        out_valid;
  logic        out_ready;
  logic [47:0] block_address;
  logic [bba_pkg::STATUS_W-1:0] status;
  logic        cfg_write;
  logic        cfg_index;
  logic [47:0] cfg_data;

  int          fail_count;
  int          outstanding;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_go;
  int          cycles;
  int unsigned cur_order;
  logic [47:0] cur_base;
  logic [47:0] live_blocks[$];
  logic [47:0] freed_blocks[$];

  buddy_block_allocator_top dut (.*);

  bba_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("buddy_block_allocator_top: mismatch");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        out_ready <= 1'b0;
        repeat (500) @(posedge clk);
        hold_go = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // addresses handed out so far, for well-formed frees
  always @(posedge clk)
    if (!rst && out_valid && out_ready && status == bba_pkg::ST_ALLOCATED)
      live_blocks.push_back(block_address);

  task automatic send(logic c, logic [31:0] req, logic [47:0] fa);
    in_valid <= 1'b1;
    cmd <= c;
    request_bytes <= req;
    free_address <= fa;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_reg(logic idx, logic [47:0] val);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == bba_pkg::CFG_POOL_ORDER) begin
      cur_order = (val[3:0] > 10) ? 10 : val[3:0];
      live_blocks.delete();
      freed_blocks.delete();
    end else begin
      cur_base = val;
    end
  endtask

  task automatic random_beat();
    int unsigned k, pick, sel;
    logic [47:0] a;
    pick = $urandom_range(99);
    if (live_blocks.size() != 0 && pick < 45) begin
      sel = $urandom_range(live_blocks.size() - 1);
      a = live_blocks[sel];
      live_blocks.delete(sel);
      freed_blocks.push_back(a);
      if (freed_blocks.size() > 16) void'(freed_blocks.pop_front());
      send(bba_pkg::CMD_FREE, $urandom, a);
    end else if (pick < 55) begin
      sel = $urandom_range(3);
      if (sel == 0 && freed_blocks.size() != 0)
        a = freed_blocks[$urandom_range(freed_blocks.size() - 1)];
      else if (sel == 1)
        a = cur_base + 48'($urandom_range((1 << cur_order) - 1) * 64) + 48'd24;
      else if (sel == 2)
        a = cur_base + 48'($urandom_range(70000));
      else
        a = {$urandom, $urandom};
      send(bba_pkg::CMD_FREE, $urandom, a);
    end else if (pick < 60) begin
      send(bba_pkg::CMD_ALLOC, $urandom, {$urandom, $urandom});
    end else begin
      k = $urandom_range(cur_order);
      send(bba_pkg::CMD_ALLOC, $urandom_range(64 << k), {$urandom, $urandom});
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = bba_pkg::CMD_ALLOC;
    request_bytes = '0;
    free_address = '0;
    cfg_write = 1'b0;
    cfg_index = bba_pkg::CFG_POOL_ORDER;
    cfg_data = '0;
    hold_go = 1'b0;
    cycles = 0;
    cur_order = 10;
    cur_base = '0;
    send_idle_pct = 34;
    recv_idle_pct = 51;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: sizes at the edges, every failure status, merges back to a full pool
    send(bba_pkg::CMD_ALLOC, 32'd0, '0);
    send(bba_pkg::CMD_ALLOC, 32'd40, '0);
    send(bba_pkg::CMD_ALLOC, 32'd41, '0);
    send(bba_pkg::CMD_ALLOC, 32'd65513, '0);
    send(bba_pkg::CMD_ALLOC, 32'hFFFF_FFFF, '0);
    send(bba_pkg::CMD_FREE, '0, 48'd0);
    send(bba_pkg::CMD_FREE, '0, 48'd23);
    send(bba_pkg::CMD_FREE, '0, 48'd65560);
    send(bba_pkg::CMD_FREE, '0, 48'hFFFF_FFFF_FFFF);
    send(bba_pkg::CMD_FREE, '0, 48'd56);
    send(bba_pkg::CMD_FREE, '0, 48'd24);
    send(bba_pkg::CMD_FREE, '0, 48'd24);
    send(bba_pkg::CMD_FREE, '0, 48'd88);
    send(bba_pkg::CMD_FREE, '0, 48'd152);
    send(bba_pkg::CMD_FREE, '0, 48'd152 + 48'd128);
    send(bba_pkg::CMD_ALLOC, 32'd65512, '0);
    send(bba_pkg::CMD_ALLOC, 32'd0, '0);
    send(bba_pkg::CMD_FREE, '0, 48'd24);
    send(bba_pkg::CMD_FREE, '0, 48'd24 + 48'd64 * 512);
    send(bba_pkg::CMD_FREE, '0, 48'd24);

    set_reg(bba_pkg::CFG_BASE_ADDR, 48'hFFFF_FFFF_0000);
    set_reg(bba_pkg::CFG_POOL_ORDER, 4'd0);
    repeat (150) random_beat();

    set_reg(bba_pkg::CFG_BASE_ADDR, {$urandom, $urandom});
    set_reg(bba_pkg::CFG_POOL_ORDER, 4'd15);
    hold_go = 1'b1;
    repeat (250) random_beat();

    send_idle_pct = 51;
    recv_idle_pct = 34;
    set_reg(bba_pkg::CFG_BASE_ADDR, 48'h0000_0000_1000);
    set_reg(bba_pkg::CFG_POOL_ORDER, 4'd3);
    repeat (200) random_beat();
    set_reg(bba_pkg::CFG_BASE_ADDR, 48'hFFFF_FFFF_FFFF);
    set_reg(bba_pkg::CFG_POOL_ORDER, 4'd10);
    repeat (200) random_beat();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_reg(bba_pkg::CFG_BASE_ADDR, 48'd0);
    set_reg(bba_pkg::CFG_POOL_ORDER, 4'd6);
    repeat (200) random_beat();
    set_reg(bba_pkg::CFG_POOL_ORDER, 4'd10);
    repeat (230) random_beat();

    wait_idle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("buddy_block_allocator_top: match");
    end else begin
      $display("buddy_block_allocator_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/bba_pkg.sv
rtl/core/bba_ram.sv
rtl/core/buddy_block_allocator_top.sv
tb/bba_checker.sv
tb/tb.sv
